// ===== design/lji_pkg.sv =====
// shared widths, stage count and rounding helper for the local jet invariants unit
package lji_pkg;

    localparam int IN_W       = 16;
    localparam int OUT_W      = 32;
    localparam int FRAC       = IN_W - 2;
    localparam int NUM_IN     = 10;
    localparam int NUM_OUT    = 9;
    localparam int IN_DATA_W  = ((NUM_IN * IN_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((NUM_OUT * OUT_W + 7) / 8) * 8;

    // intermediate widths, sized for the worst-case magnitude of each term
    localparam int SUM1_W  = IN_W + 1;
    localparam int PROD_W  = 2 * IN_W;
    localparam int PRD2S_W = 2 * IN_W + 1;
    localparam int N_W     = 2 * IN_W + 1;
    localparam int HSQ_W   = 2 * IN_W + 3;
    localparam int TR_W    = 2 * IN_W + 2;
    localparam int PRD3_W  = 3 * IN_W;
    localparam int D3_W    = 3 * IN_W + 2;
    localparam int D4_W    = 4 * IN_W + 4;
    localparam int WIDE_W  = (D4_W + 1 > OUT_W + 1) ? D4_W + 1 : OUT_W + 1;

    // right shifts that bring degree 2, 3 and 4 terms back to one fraction scale
    localparam int DEG1_SH = 0;
    localparam int DEG2_SH = FRAC;
    localparam int DEG3_SH = 2 * FRAC;
    localparam int DEG4_SH = 3 * FRAC;

    localparam int LATENCY = 7;

    // round half up, arithmetic shift, clamp to the output range
    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [WIDE_W-1:0] x,
        input int                       sh
    );
        logic signed [WIDE_W-1:0] y;
        logic signed [WIDE_W-1:0] maxv;
        logic signed [WIDE_W-1:0] minv;
        maxv = {{(WIDE_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
        minv = ~maxv;
        if (sh == 0)
        begin
            y = x;
        end
        else
        begin
            y = x + $signed(WIDE_W'(1) << (sh - 1));
            y = y >>> sh;
        end
        if (y > maxv)
        begin
            round_sat = maxv[OUT_W-1:0];
        end
        else if (y < minv)
        begin
            round_sat = minv[OUT_W-1:0];
        end
        else
        begin
            round_sat = y[OUT_W-1:0];
        end
    endfunction

endpackage

// ===== design/local_jet_invariants_unit.sv =====
// local jet invariants unit: nine rotation invariants per point, seven-stage pipeline
//
// usage
//   s_axis carries one item per image point: ten signed Q1.14 derivative
//   responses (L, Lx, Ly, Lxx, Lxy, Lyy, Lxxx, Lxxy, Lxyy, Lyyy) packed in tdata.
//   m_axis returns one item per input item: nine signed 32-bit Q14 invariants,
//   the polynomial ones rounded half up and clamped to the 32-bit range.
//   with tready held high, an item passes the seven register stages, each holding
//   one row of multipliers or adders, and then raises m_axis_tvalid; throughput
//   is one item per cycle while the receiver keeps tready high.
//   the deepest path is the fourth-order chain: gradient products, then
//   third-order contractions, then one more gradient multiply and two subtracts.
//   each stage has its own valid bit; a stage loads when it is empty or when
//   the stage after it moves, so bubbles close up and s_axis_tready stays high
//   while the output register holds a waiting item and earlier stages are free.
//   when the receiver stalls, items pile up stage by stage; none is dropped
//   or repeated, and tready falls only once all seven stages are full.
//   reset clears the valid bits only; the data registers are not reset.
module local_jet_invariants_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // smoothed_value, deriv_x, deriv_y, deriv_xx, deriv_xy, deriv_yy,
    // deriv_xxx, deriv_xxy, deriv_xyy, deriv_yyy
    input  logic [lji_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // inv_intensity, inv_grad_sq, inv_grad_hess_grad, inv_laplacian, inv_hess_sq,
    // inv_third_a, inv_third_b, inv_third_c, inv_third_d
    output logic [lji_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int LAT = lji_pkg::LATENCY;

    // input field views
    logic signed [lji_pkg::IN_W-1:0] in_l, in_a, in_b, in_p, in_q, in_r;
    logic signed [lji_pkg::IN_W-1:0] in_t0, in_t1, in_t2, in_t3;

    assign in_l  = s_axis_tdata[0*lji_pkg::IN_W +: lji_pkg::IN_W];
    assign in_a  = s_axis_tdata[1*lji_pkg::IN_W +: lji_pkg::IN_W];
    assign in_b  = s_axis_tdata[2*lji_pkg::IN_W +: lji_pkg::IN_W];
    assign in_p  = s_axis_tdata[3*lji_pkg::IN_W +: lji_pkg::IN_W];
    assign in_q  = s_axis_tdata[4*lji_pkg::IN_W +: lji_pkg::IN_W];
    assign in_r  = s_axis_tdata[5*lji_pkg::IN_W +: lji_pkg::IN_W];
    assign in_t0 = s_axis_tdata[6*lji_pkg::IN_W +: lji_pkg::IN_W];
    assign in_t1 = s_axis_tdata[7*lji_pkg::IN_W +: lji_pkg::IN_W];
    assign in_t2 = s_axis_tdata[8*lji_pkg::IN_W +: lji_pkg::IN_W];
    assign in_t3 = s_axis_tdata[9*lji_pkg::IN_W +: lji_pkg::IN_W];

    // ------------------------------------------------------------------
    // flow control: per-stage valid and advance
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic [LAT-1:0] adv;

    always_comb
    begin
        adv[LAT-1] = !vld_reg[LAT-1] || m_axis_tready;
        for (int k = LAT - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign vld_next = {vld_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < LAT; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = vld_reg[LAT-1];

    // ------------------------------------------------------------------
    // stage 1: gradient and hessian squares, third-order pair sums
    // ------------------------------------------------------------------
    logic signed [lji_pkg::IN_W-1:0]   s1_l_reg, s1_a_reg, s1_b_reg;
    logic signed [lji_pkg::IN_W-1:0]   s1_p_reg, s1_q_reg, s1_r_reg;
    logic signed [lji_pkg::IN_W-1:0]   s1_t0_reg, s1_t1_reg, s1_t2_reg, s1_t3_reg;
    logic signed [lji_pkg::PROD_W-1:0] s1_aa_reg, s1_ab_reg, s1_bb_reg;
    logic signed [lji_pkg::PROD_W-1:0] s1_pp_reg, s1_qq_reg, s1_rr_reg;
    logic signed [lji_pkg::SUM1_W-1:0] s1_lap_reg, s1_s02_reg, s1_s13_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_l_reg   <= in_l;
            s1_a_reg   <= in_a;
            s1_b_reg   <= in_b;
            s1_p_reg   <= in_p;
            s1_q_reg   <= in_q;
            s1_r_reg   <= in_r;
            s1_t0_reg  <= in_t0;
            s1_t1_reg  <= in_t1;
            s1_t2_reg  <= in_t2;
            s1_t3_reg  <= in_t3;
            s1_aa_reg  <= in_a * in_a;
            s1_ab_reg  <= in_a * in_b;
            s1_bb_reg  <= in_b * in_b;
            s1_pp_reg  <= in_p * in_p;
            s1_qq_reg  <= in_q * in_q;
            s1_rr_reg  <= in_r * in_r;
            s1_lap_reg <= lji_pkg::SUM1_W'(in_p) + lji_pkg::SUM1_W'(in_r);
            s1_s02_reg <= lji_pkg::SUM1_W'(in_t0) + lji_pkg::SUM1_W'(in_t2);
            s1_s13_reg <= lji_pkg::SUM1_W'(in_t1) + lji_pkg::SUM1_W'(in_t3);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: third-degree products, gradient norm, hessian norm
    // ------------------------------------------------------------------
    logic signed [lji_pkg::IN_W-1:0]    s2_l_reg, s2_a_reg, s2_b_reg;
    logic signed [lji_pkg::SUM1_W-1:0]  s2_lap_reg;
    logic signed [lji_pkg::N_W-1:0]     s2_n_reg;
    logic signed [lji_pkg::HSQ_W-1:0]   s2_hsq_reg;
    logic signed [lji_pkg::PRD3_W-1:0]  s2_aap_reg, s2_abq_reg, s2_bbr_reg;
    logic signed [lji_pkg::PRD3_W-1:0]  s2_aat0_reg, s2_abt1_reg, s2_bbt2_reg;
    logic signed [lji_pkg::PRD3_W-1:0]  s2_aat1_reg, s2_abt2_reg, s2_bbt3_reg;
    logic signed [lji_pkg::PRD2S_W-1:0] s2_as02_reg, s2_bs13_reg;
    logic signed [lji_pkg::PRD2S_W-1:0] s2_as13_reg, s2_bs02_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_l_reg    <= s1_l_reg;
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_lap_reg  <= s1_lap_reg;
            s2_n_reg    <= lji_pkg::N_W'(s1_aa_reg) + lji_pkg::N_W'(s1_bb_reg);
            s2_hsq_reg  <= lji_pkg::HSQ_W'(s1_pp_reg)
                           + (lji_pkg::HSQ_W'(s1_qq_reg) <<< 1)
                           + lji_pkg::HSQ_W'(s1_rr_reg);
            s2_aap_reg  <= s1_aa_reg * s1_p_reg;
            s2_abq_reg  <= s1_ab_reg * s1_q_reg;
            s2_bbr_reg  <= s1_bb_reg * s1_r_reg;
            s2_aat0_reg <= s1_aa_reg * s1_t0_reg;
            s2_abt1_reg <= s1_ab_reg * s1_t1_reg;
            s2_bbt2_reg <= s1_bb_reg * s1_t2_reg;
            s2_aat1_reg <= s1_aa_reg * s1_t1_reg;
            s2_abt2_reg <= s1_ab_reg * s1_t2_reg;
            s2_bbt3_reg <= s1_bb_reg * s1_t3_reg;
            s2_as02_reg <= s1_a_reg * s1_s02_reg;
            s2_bs13_reg <= s1_b_reg * s1_s13_reg;
            s2_as13_reg <= s1_a_reg * s1_s13_reg;
            s2_bs02_reg <= s1_b_reg * s1_s02_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: third-degree sums, trace and cross terms
    // ------------------------------------------------------------------
    logic signed [lji_pkg::IN_W-1:0]   s3_l_reg, s3_a_reg, s3_b_reg;
    logic signed [lji_pkg::SUM1_W-1:0] s3_lap_reg;
    logic signed [lji_pkg::N_W-1:0]    s3_n_reg;
    logic signed [lji_pkg::HSQ_W-1:0]  s3_hsq_reg;
    logic signed [lji_pkg::D3_W-1:0]   s3_ghg_reg, s3_ct0_reg, s3_ct1_reg;
    logic signed [lji_pkg::TR_W-1:0]   s3_tr_reg, s3_cr_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_l_reg   <= s2_l_reg;
            s3_a_reg   <= s2_a_reg;
            s3_b_reg   <= s2_b_reg;
            s3_lap_reg <= s2_lap_reg;
            s3_n_reg   <= s2_n_reg;
            s3_hsq_reg <= s2_hsq_reg;
            s3_ghg_reg <= lji_pkg::D3_W'(s2_aap_reg)
                          + (lji_pkg::D3_W'(s2_abq_reg) <<< 1)
                          + lji_pkg::D3_W'(s2_bbr_reg);
            s3_ct0_reg <= lji_pkg::D3_W'(s2_aat0_reg)
                          + (lji_pkg::D3_W'(s2_abt1_reg) <<< 1)
                          + lji_pkg::D3_W'(s2_bbt2_reg);
            s3_ct1_reg <= lji_pkg::D3_W'(s2_aat1_reg)
                          + (lji_pkg::D3_W'(s2_abt2_reg) <<< 1)
                          + lji_pkg::D3_W'(s2_bbt3_reg);
            s3_tr_reg  <= lji_pkg::TR_W'(s2_as02_reg) + lji_pkg::TR_W'(s2_bs13_reg);
            s3_cr_reg  <= lji_pkg::TR_W'(s2_as13_reg) - lji_pkg::TR_W'(s2_bs02_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: fourth-degree products
    // ------------------------------------------------------------------
    logic signed [lji_pkg::IN_W-1:0]   s4_l_reg;
    logic signed [lji_pkg::SUM1_W-1:0] s4_lap_reg;
    logic signed [lji_pkg::N_W-1:0]    s4_n_reg;
    logic signed [lji_pkg::HSQ_W-1:0]  s4_hsq_reg;
    logic signed [lji_pkg::D3_W-1:0]   s4_ghg_reg;
    logic signed [lji_pkg::D4_W-1:0]   s4_at0_reg, s4_bt1_reg, s4_bt0_reg, s4_at1_reg;
    logic signed [lji_pkg::D4_W-1:0]   s4_ntr_reg, s4_ncr_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_l_reg   <= s3_l_reg;
            s4_lap_reg <= s3_lap_reg;
            s4_n_reg   <= s3_n_reg;
            s4_hsq_reg <= s3_hsq_reg;
            s4_ghg_reg <= s3_ghg_reg;
            s4_at0_reg <= s3_a_reg * s3_ct0_reg;
            s4_bt1_reg <= s3_b_reg * s3_ct1_reg;
            s4_bt0_reg <= s3_b_reg * s3_ct0_reg;
            s4_at1_reg <= s3_a_reg * s3_ct1_reg;
            s4_ntr_reg <= s3_n_reg * s3_tr_reg;
            s4_ncr_reg <= s3_n_reg * s3_cr_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: full contraction and antisymmetric contraction
    // ------------------------------------------------------------------
    logic signed [lji_pkg::IN_W-1:0]   s5_l_reg;
    logic signed [lji_pkg::SUM1_W-1:0] s5_lap_reg;
    logic signed [lji_pkg::N_W-1:0]    s5_n_reg;
    logic signed [lji_pkg::HSQ_W-1:0]  s5_hsq_reg;
    logic signed [lji_pkg::D3_W-1:0]   s5_ghg_reg;
    logic signed [lji_pkg::D4_W-1:0]   s5_inv8_reg, s5_inv7_reg, s5_ntr_reg, s5_ncr_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_l_reg    <= s4_l_reg;
            s5_lap_reg  <= s4_lap_reg;
            s5_n_reg    <= s4_n_reg;
            s5_hsq_reg  <= s4_hsq_reg;
            s5_ghg_reg  <= s4_ghg_reg;
            s5_inv8_reg <= s4_at0_reg + s4_bt1_reg;
            s5_inv7_reg <= s4_bt0_reg - s4_at1_reg;
            s5_ntr_reg  <= s4_ntr_reg;
            s5_ncr_reg  <= s4_ncr_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: remaining fourth-order invariants
    // ------------------------------------------------------------------
    logic signed [lji_pkg::IN_W-1:0]   s6_l_reg;
    logic signed [lji_pkg::SUM1_W-1:0] s6_lap_reg;
    logic signed [lji_pkg::N_W-1:0]    s6_n_reg;
    logic signed [lji_pkg::HSQ_W-1:0]  s6_hsq_reg;
    logic signed [lji_pkg::D3_W-1:0]   s6_ghg_reg;
    logic signed [lji_pkg::D4_W-1:0]   s6_inv5_reg, s6_inv6_reg, s6_inv7_reg, s6_inv8_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_l_reg    <= s5_l_reg;
            s6_lap_reg  <= s5_lap_reg;
            s6_n_reg    <= s5_n_reg;
            s6_hsq_reg  <= s5_hsq_reg;
            s6_ghg_reg  <= s5_ghg_reg;
            s6_inv6_reg <= s5_ntr_reg - s5_inv8_reg;
            s6_inv5_reg <= -s5_inv7_reg - s5_ncr_reg;
            s6_inv7_reg <= s5_inv7_reg;
            s6_inv8_reg <= s5_inv8_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: rescale, round, clamp into the output register
    // ------------------------------------------------------------------
    logic signed [lji_pkg::OUT_W-1:0] out_inv0_reg, out_inv1_reg, out_inv2_reg;
    logic signed [lji_pkg::OUT_W-1:0] out_inv3_reg, out_inv4_reg, out_inv5_reg;
    logic signed [lji_pkg::OUT_W-1:0] out_inv6_reg, out_inv7_reg, out_inv8_reg;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            out_inv0_reg <= lji_pkg::round_sat(lji_pkg::WIDE_W'(s6_l_reg),
                                               lji_pkg::DEG1_SH);
            out_inv1_reg <= lji_pkg::round_sat(lji_pkg::WIDE_W'(s6_n_reg),
                                               lji_pkg::DEG2_SH);
            out_inv2_reg <= lji_pkg::round_sat(lji_pkg::WIDE_W'(s6_ghg_reg),
                                               lji_pkg::DEG3_SH);
            out_inv3_reg <= lji_pkg::round_sat(lji_pkg::WIDE_W'(s6_lap_reg),
                                               lji_pkg::DEG1_SH);
            out_inv4_reg <= lji_pkg::round_sat(lji_pkg::WIDE_W'(s6_hsq_reg),
                                               lji_pkg::DEG2_SH);
            out_inv5_reg <= lji_pkg::round_sat(lji_pkg::WIDE_W'(s6_inv5_reg),
                                               lji_pkg::DEG4_SH);
            out_inv6_reg <= lji_pkg::round_sat(lji_pkg::WIDE_W'(s6_inv6_reg),
                                               lji_pkg::DEG4_SH);
            out_inv7_reg <= lji_pkg::round_sat(lji_pkg::WIDE_W'(s6_inv7_reg),
                                               lji_pkg::DEG4_SH);
            out_inv8_reg <= lji_pkg::round_sat(lji_pkg::WIDE_W'(s6_inv8_reg),
                                               lji_pkg::DEG4_SH);
        end
    end

    assign m_axis_tdata = lji_pkg::OUT_DATA_W'({out_inv8_reg, out_inv7_reg, out_inv6_reg,
                                                out_inv5_reg, out_inv4_reg, out_inv3_reg,
                                                out_inv2_reg, out_inv1_reg, out_inv0_reg});

endmodule

// ===== design/lji_checker.sv =====
// port-level checks for the local jet invariants unit, bound to the top level
module lji_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [lji_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lji_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic                             in_acc;
    logic signed [lji_pkg::OUT_W-1:0] l_ext;
    logic signed [lji_pkg::OUT_W-1:0] lap_ext;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign l_ext   = lji_pkg::OUT_W'($signed(s_axis_tdata[lji_pkg::IN_W-1:0]));
    assign lap_ext = lji_pkg::OUT_W'($signed(s_axis_tdata[3*lji_pkg::IN_W +: lji_pkg::IN_W]))
                     + lji_pkg::OUT_W'($signed(s_axis_tdata[5*lji_pkg::IN_W +: lji_pkg::IN_W]));

    // a stalled output item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

    // with the output stage free or draining, the pipe must take input
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input blocked while the output stage moves");

    // unstalled run: an accepted item reaches the output with its degree-one fields intact
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_acc, lji_pkg::LATENCY)
        && $past(m_axis_tready, 1) && $past(m_axis_tready, 2) && $past(m_axis_tready, 3)
        && $past(m_axis_tready, 4) && $past(m_axis_tready, 5) && $past(m_axis_tready, 6)
        && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
        && $past(rst_n, 4) && $past(rst_n, 5) && $past(rst_n, 6)
        && $past(rst_n, lji_pkg::LATENCY)
        |-> m_axis_tvalid
            && $signed(m_axis_tdata[lji_pkg::OUT_W-1:0]) == $past(l_ext, lji_pkg::LATENCY)
            && $signed(m_axis_tdata[3*lji_pkg::OUT_W +: lji_pkg::OUT_W])
               == $past(lap_ext, lji_pkg::LATENCY))
    else $error("item lost, late or corrupted through the pipe");

endmodule

bind local_jet_invariants_unit lji_checker u_lji_checker (.*);
